[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the inversion counter.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, off while in reset.
`define IC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define IC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ic_pkg.sv]
// Shared types and constants of the inversion counter.
// No dependencies.
package ic_pkg;

  localparam int VALUE_W     = 32;
  localparam int TOTAL_W     = 15;
  localparam int MAX_ITEMS_D = 256;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // one value moving down the cell chain
  typedef struct packed {
    logic                      vld;
    logic                      last;
    logic                      placed;  // already stored in some cell
    logic signed [VALUE_W-1:0] value;
  } tok_t;

endpackage

[hdl/ic_cell.sv]
// One cell of the inversion counter chain: holds one stored value.
// Depends on ic_pkg.
module ic_cell #(
  parameter int CW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  ic_pkg::tok_t   tok_i,
  input  logic [CW-1:0]  gt_i,
  output ic_pkg::tok_t   tok_o,
  output logic [CW-1:0]  gt_o,
  output logic           held
);

  logic                              valid_r, valid_nxt;
  logic signed [ic_pkg::VALUE_W-1:0] val_r, val_nxt;
  ic_pkg::tok_t                      tok_r, tok_nxt;
  logic [CW-1:0]                     gt_r, gt_nxt;
  logic                              hit;
  logic                              inc;

  always_comb begin
    hit = tok_i.vld && !tok_i.placed && !valid_r;
    inc = tok_i.vld && valid_r && (val_r > tok_i.value);
    tok_nxt        = tok_i;
    tok_nxt.placed = tok_i.placed | hit;
    gt_nxt         = gt_i + CW'(inc);
    val_nxt        = hit ? tok_i.value : val_r;
    // the last value of a run empties each cell it passes
    if (tok_i.vld && tok_i.last) begin
      valid_nxt = 1'b0;
    end else if (hit) begin
      valid_nxt = 1'b1;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= val_nxt;
      gt_r  <= gt_nxt;
    end
  end

  assign tok_o = tok_r;
  assign gt_o  = gt_r;
  assign held  = valid_r;

endmodule

[hdl/ic_tail.sv]
// End of the cell chain: running total, overflow flag and result register.
// Depends on ic_pkg.
module ic_tail #(
  parameter int CW = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  ic_pkg::tok_t               tok_i,
  input  logic [CW-1:0]              gt_i,
  output logic                       stall,
  output logic                       res_valid,
  output logic [ic_pkg::TOTAL_W-1:0] res_total,
  output logic                       res_ovf,
  input  logic                       res_ready
);

  localparam int TW = ic_pkg::TOTAL_W;

  logic [TW-1:0] total_r, total_nxt;
  logic          ovf_r, ovf_nxt;
  logic          oval_r;
  logic [TW-1:0] otot_r;
  logic          oovf_r;
  logic [TW:0]   sum;

  always_comb begin
    sum = {1'b0, total_r} + (TW+1)'(gt_i);
    // a value that found no free cell was dropped
    if (tok_i.placed) begin
      total_nxt = sum[TW] ? ic_pkg::TOTAL_MAX : sum[TW-1:0];
      ovf_nxt   = ovf_r;
    end else begin
      total_nxt = total_r;
      ovf_nxt   = 1'b1;
    end
  end

  assign stall = tok_i.vld && tok_i.last && oval_r && !res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      ovf_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      if (adv && tok_i.vld) begin
        if (tok_i.last) begin
          total_r <= '0;
          ovf_r   <= 1'b0;
        end else begin
          total_r <= total_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
      if (adv && tok_i.vld && tok_i.last) begin
        oval_r <= 1'b1;
      end else if (res_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_i.vld && tok_i.last) begin
      otot_r <= total_nxt;
      oovf_r <= ovf_nxt;
    end
  end

  assign res_valid = oval_r;
  assign res_total = otot_r;
  assign res_ovf   = oovf_r;

endmodule

[hdl/inversion_counter.sv]
// Inversion counter top level: a chain of MAX_ITEMS cells plus a tail stage.
// Depends on ic_pkg, ic_cell, ic_tail and assert_macros.svh.

// Counts pairs in a run of signed 32-bit values where an earlier value is
// strictly greater than a later one; equal values do not count. One value is
// taken per cycle while the chain is not halted. Each value walks down a
// chain of MAX_ITEMS cells, one cell a cycle unless halted, picking up a
// count of stored values greater than itself, and is stored in the first
// empty cell. The run total is offered once the last value has passed every
// cell: the result register loads as it leaves the last one. Values beyond
// MAX_ITEMS in a run are dropped and set the overflow flag. The total
// saturates at 32767. The whole chain halts only while a finished result is
// waiting and the next run's last value reaches the tail. Reset empties the
// cells at once; there is no clearing pass.
`include "assert_macros.svh"

module inversion_counter #(
  parameter int MAX_ITEMS = ic_pkg::MAX_ITEMS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [14:0] inversions, [15] overflow
);

  localparam int CW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  ic_pkg::tok_t                 tok_c [MAX_ITEMS+1];
  logic [CW-1:0]                gt_c  [MAX_ITEMS+1];
  logic [MAX_ITEMS-1:0]         held;
  logic                         adv;
  logic                         stall;
  logic                         res_valid;
  logic [ic_pkg::TOTAL_W-1:0]   res_total;
  logic                         res_ovf;
  logic                         tail_vld;
  logic                         tail_last;
  logic                         tail_drop;

  assign adv       = !stall;
  assign in_tready = adv;

  assign tok_c[0] = '{vld: in_tvalid, last: in_tlast, placed: 1'b0, value: in_tdata};
  assign gt_c[0]  = '0;

  for (genvar j = 0; j < MAX_ITEMS; j++) begin : g_cell
    ic_cell #(.CW(CW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok_c[j]),
      .gt_i  (gt_c[j]),
      .tok_o (tok_c[j+1]),
      .gt_o  (gt_c[j+1]),
      .held  (held[j])
    );
  end

  ic_tail #(.CW(CW)) u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .tok_i     (tok_c[MAX_ITEMS]),
    .gt_i      (gt_c[MAX_ITEMS]),
    .stall     (stall),
    .res_valid (res_valid),
    .res_total (res_total),
    .res_ovf   (res_ovf),
    .res_ready (out_tready)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {res_ovf, res_total};

  assign tail_vld  = tok_c[MAX_ITEMS].vld;
  assign tail_last = tok_c[MAX_ITEMS].last;
  assign tail_drop = tail_vld && !tok_c[MAX_ITEMS].placed && !tail_last;

  // the input side only backs up behind a waiting result
  `IC_ASSERT(a_stall_cause, !in_tready |-> (out_tvalid && !out_tready), "stall, no result")
  // a new result only comes from the last value of a run at the tail
  `IC_ASSERT(a_res_src, $rose(out_tvalid) |-> $past(tail_vld && tail_last), "stray result")
  // a value still unplaced at the tail means every cell was occupied
  `IC_ASSERT(a_drop_full, tail_drop |-> held[MAX_ITEMS-1], "dropped value with free cell")
  // cells hold nothing right after reset
  `IC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> (held == '0), "cells not empty after reset")

endmodule
